>>> src/msfd_pkg.sv
// ----------------------------------------------------------------------------
// msfd_pkg: shared types and constants of the motor status frame decoder
// item layouts, frame constants and the fault priority encoder
// ----------------------------------------------------------------------------
package msfd_pkg;

  // frame layout, byte positions counted from the start byte
  localparam logic [7:0] PosStart   = 8'd0;
  localparam logic [7:0] PosLength  = 8'd1;
  localparam logic [7:0] PosCommand = 8'd2;
  localparam logic [7:0] PosFlags   = 8'd3;
  localparam logic [7:0] PosCurHi   = 8'd5;
  localparam logic [7:0] PosCurLo   = 8'd6;
  localparam logic [7:0] PosPerHi   = 8'd8;
  localparam logic [7:0] PosPerLo   = 8'd9;
  localparam logic [7:0] PosCharge  = 8'd10;

  localparam logic [7:0]  StartCode   = 8'h02;
  localparam logic [7:0]  MinFrameLen = 8'd14;
  localparam logic [7:0]  StatusCmd   = 8'd1;
  localparam logic [7:0]  CountMax    = 8'd255;
  localparam logic [7:0]  ChargeMax   = 8'd100;
  localparam logic [17:0] CurrentMax  = 18'd32767;
  localparam int unsigned FineBit     = 14;

  // fault codes, dense numbering of the priority order
  localparam logic [2:0] FaultNone = 3'd0;
  localparam logic [2:0] FaultBit1 = 3'd1;
  localparam logic [2:0] FaultBit3 = 3'd2;
  localparam logic [2:0] FaultBit0 = 3'd3;
  localparam logic [2:0] FaultBit5 = 3'd4;
  localparam logic [2:0] FaultBit4 = 3'd5;
  localparam logic [2:0] FaultBit6 = 3'd6;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } msfd_in_t;

  typedef struct packed {
    logic        frame_ok;
    logic [7:0]  status_flags;
    logic [2:0]  fault_code;
    logic        flag_two;
    logic        flag_seven;
    logic [14:0] current_deciamps;
    logic [15:0] period_millis;
    logic [7:0]  charge_percent;
    logic        charge_valid;
  } msfd_out_t;

  function automatic logic [2:0] fault_of(input logic [7:0] flags);
    logic [2:0] code;
    priority if (flags[1]) code = FaultBit1;
    else if (flags[3])     code = FaultBit3;
    else if (flags[0])     code = FaultBit0;
    else if (flags[5])     code = FaultBit5;
    else if (flags[4])     code = FaultBit4;
    else if (flags[6])     code = FaultBit6;
    else                   code = FaultNone;
    return code;
  endfunction

endpackage

>>> src/msfd_intf.sv
// ----------------------------------------------------------------------------
// msfd_intf: valid/ready channels of the motor status frame decoder
// one channel for received bytes, one for decoded frame results
// ----------------------------------------------------------------------------
interface msfd_in_if;
  import msfd_pkg::*;

  logic     valid;
  logic     ready;
  msfd_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface msfd_out_if;
  import msfd_pkg::*;

  logic      valid;
  logic      ready;
  msfd_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/motor_status_frame_decoder.sv
// ----------------------------------------------------------------------------
// motor_status_frame_decoder: byte-wise motor status frame decoder
// result: registered, a result item appears in the cycle after the byte item that ends the frame is taken
// throughput: one byte item per cycle while pending result items are taken, set by the single result register stage
// reset: byte count and captured fields clear, no result item pending
// ----------------------------------------------------------------------------
module motor_status_frame_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  msfd_in_if.sink    in_i,
  msfd_out_if.source out_o
);
  import msfd_pkg::*;

  // frame capture state
  logic [7:0]  count_q, count_d;
  logic        start_ok_q, start_ok_d;
  logic [7:0]  length_q, length_d;
  logic [7:0]  command_q, command_d;
  logic [7:0]  flags_q, flags_d;
  logic [15:0] cur_word_q, cur_word_d;
  logic [15:0] per_word_q, per_word_d;
  logic [7:0]  charge_q, charge_d;

  // values after this byte, before the end-of-frame clear
  logic [7:0]  cnt_next;
  logic        start_next;
  logic [7:0]  len_next;
  logic [7:0]  cmd_next;
  logic [7:0]  flg_next;
  logic [15:0] cur_next;
  logic [15:0] per_next;
  logic [7:0]  chg_next;

  logic        frame_ok;
  logic [13:0] cur_raw;
  logic [17:0] cur_scaled;
  logic [14:0] cur_sat;
  msfd_out_t   res;

  // result register, the output side of the block
  logic        out_valid_q;
  msfd_out_t   out_q;

  logic        accept;
  logic        last;

  // a new byte goes in whenever the result register is free or being drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign last       = in_i.data.frame_end;

  always_comb begin
    start_next = start_ok_q;
    len_next   = length_q;
    cmd_next   = command_q;
    flg_next   = flags_q;
    cur_next   = cur_word_q;
    per_next   = per_word_q;
    chg_next   = charge_q;
    // capture the byte at its position in the frame
    unique case (count_q)
      PosStart:   start_next = (in_i.data.rx_byte == StartCode);
      PosLength:  len_next = in_i.data.rx_byte;
      PosCommand: cmd_next = in_i.data.rx_byte;
      PosFlags:   flg_next = in_i.data.rx_byte;
      PosCurHi:   cur_next = {in_i.data.rx_byte, cur_word_q[7:0]};
      PosCurLo:   cur_next = {cur_word_q[15:8], in_i.data.rx_byte};
      PosPerHi:   per_next = {in_i.data.rx_byte, per_word_q[7:0]};
      PosPerLo:   per_next = {per_word_q[15:8], in_i.data.rx_byte};
      PosCharge:  chg_next = in_i.data.rx_byte;
      default: begin
        // bytes at all other positions are only counted
      end
    endcase
    // saturating byte counter
    cnt_next = (count_q != CountMax) ? count_q + 8'd1 : count_q;
  end

  // frame checks use the count including the closing byte
  assign frame_ok = (cnt_next >= MinFrameLen) && start_next &&
                    (len_next >= MinFrameLen) && (len_next <= cnt_next) &&
                    (cmd_next == StatusCmd);

  // current scaling: raw value, or raw times ten as 8x + 2x, then saturate
  assign cur_raw    = cur_next[13:0];
  assign cur_scaled = cur_next[FineBit] ? {4'd0, cur_raw}
                                        : ({1'b0, cur_raw, 3'd0} + {3'd0, cur_raw, 1'b0});
  assign cur_sat    = (cur_scaled > CurrentMax) ? CurrentMax[14:0] : cur_scaled[14:0];

  always_comb begin
    res = '0;
    // rejected frames report all fields as zero
    if (frame_ok) begin
      res.frame_ok         = 1'b1;
      res.status_flags     = flg_next;
      res.fault_code       = fault_of(flg_next);
      res.flag_two         = flg_next[2];
      res.flag_seven       = flg_next[7];
      res.current_deciamps = cur_sat;
      res.period_millis    = per_next;
      res.charge_percent   = chg_next;
      res.charge_valid     = (chg_next <= ChargeMax);
    end
  end

  // next state: hold when idle, advance on a byte, clear at frame end
  always_comb begin
    count_d    = count_q;
    start_ok_d = start_ok_q;
    length_d   = length_q;
    command_d  = command_q;
    flags_d    = flags_q;
    cur_word_d = cur_word_q;
    per_word_d = per_word_q;
    charge_d   = charge_q;
    if (accept) begin
      if (last) begin
        count_d    = '0;
        start_ok_d = 1'b0;
        length_d   = '0;
        command_d  = '0;
        flags_d    = '0;
        cur_word_d = '0;
        per_word_d = '0;
        charge_d   = '0;
      end else begin
        count_d    = cnt_next;
        start_ok_d = start_next;
        length_d   = len_next;
        command_d  = cmd_next;
        flags_d    = flg_next;
        cur_word_d = cur_next;
        per_word_d = per_next;
        charge_d   = chg_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      start_ok_q <= 1'b0;
      length_q   <= '0;
      command_q  <= '0;
      flags_q    <= '0;
      cur_word_q <= '0;
      per_word_q <= '0;
      charge_q   <= '0;
    end else begin
      count_q    <= count_d;
      start_ok_q <= start_ok_d;
      length_q   <= length_d;
      command_q  <= command_d;
      flags_q    <= flags_d;
      cur_word_q <= cur_word_d;
      per_word_q <= per_word_d;
      charge_q   <= charge_d;
    end
  end

  // result valid flag: set by a closing byte, cleared when the item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && last) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept && last) begin
      out_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression of the motor status frame decoder
// frames go in a byte at a time under random valid/ready gaps; each decoded
// frame item is checked field by field against a cycle-free frame decoder
// ----------------------------------------------------------------------------
module testbench;
  import msfd_pkg::*;

  localparam int unsigned ItemsTarget = 650;
  localparam int unsigned LongFrameNo = 24;  // frame that runs the count into saturation
  localparam int unsigned PauseFrameNo = 8;  // sender drains the decoder after this frame
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned DrainCycles = 4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
    logic       typed;      // expected item written out below, else taken from the decoder
    msfd_out_t  want;
  } byte_row_t;

  localparam msfd_out_t NoFrame = '0;
  // current and period at their top values, flags all set, charge just past full
  localparam msfd_out_t FullScaleFrame = '{
    frame_ok: 1'b1, status_flags: 8'hFF, fault_code: FaultBit1, flag_two: 1'b1,
    flag_seven: 1'b1, current_deciamps: 15'd16383, period_millis: 16'hFFFF,
    charge_percent: 8'd101, charge_valid: 1'b0
  };

  // directed bytes: two one-byte frames, then one full-scale status frame
  localparam byte_row_t ByteRows [16] = '{
    '{8'h02, 1'b1, 1'b1, NoFrame},        // start byte alone is too short
    '{8'hFF, 1'b1, 1'b1, NoFrame},
    '{8'h02, 1'b0, 1'b0, NoFrame},        // start
    '{8'h0E, 1'b0, 1'b0, NoFrame},        // declared length 14
    '{8'h01, 1'b0, 1'b0, NoFrame},        // status command
    '{8'hFF, 1'b0, 1'b0, NoFrame},        // flags
    '{8'h00, 1'b0, 1'b0, NoFrame},
    '{8'h7F, 1'b0, 1'b0, NoFrame},        // current high, fine scale
    '{8'hFF, 1'b0, 1'b0, NoFrame},        // current low
    '{8'h00, 1'b0, 1'b0, NoFrame},
    '{8'hFF, 1'b0, 1'b0, NoFrame},        // period high
    '{8'hFF, 1'b0, 1'b0, NoFrame},        // period low
    '{8'h65, 1'b0, 1'b0, NoFrame},        // charge 101
    '{8'h00, 1'b0, 1'b0, NoFrame},
    '{8'h00, 1'b0, 1'b0, NoFrame},
    '{8'hFF, 1'b1, 1'b1, FullScaleFrame}  // xor byte, never checked
  };

  logic clk;
  logic rst_n;

  msfd_in_if  in_ch ();
  msfd_out_if out_ch ();

  motor_status_frame_decoder uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // decoder state, mirrors what the block captures from the current frame
  logic [7:0]  seen_count = '0;
  logic        seen_start_ok = 1'b0;
  logic [7:0]  seen_length = '0;
  logic [7:0]  seen_command = '0;
  logic [7:0]  seen_flags = '0;
  logic [15:0] seen_current = '0;
  logic [15:0] seen_period = '0;
  logic [7:0]  seen_charge = '0;

  msfd_out_t   decoded_q [$];   // decoded frames not yet delivered
  int unsigned bytes_sent = 0;
  int unsigned frames_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  bit          steady_tx = 1'b0; // sender offers back to back
  msfd_out_t   got_frame;
  msfd_out_t   want_frame;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // feed one byte; returns 1 with the decoded frame when the byte closes it
  function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                     output msfd_out_t res);
    int unsigned amps;
    bit ok;
    res = NoFrame;
    case (seen_count)
      PosStart:   seen_start_ok = (b == StartCode);
      PosLength:  seen_length = b;
      PosCommand: seen_command = b;
      PosFlags:   seen_flags = b;
      PosCurHi:   seen_current[15:8] = b;
      PosCurLo:   seen_current[7:0] = b;
      PosPerHi:   seen_period[15:8] = b;
      PosPerLo:   seen_period[7:0] = b;
      PosCharge:  seen_charge = b;
      default: ;
    endcase
    if (seen_count != CountMax) seen_count = seen_count + 8'd1;
    if (!last) return 1'b0;

    ok = seen_count >= MinFrameLen && seen_start_ok && seen_length >= MinFrameLen &&
         seen_length <= seen_count && seen_command == StatusCmd;
    if (ok) begin
      // 14-bit reading, coarse scale unless the fine bit is set
      amps = 32'(seen_current[13:0]);
      if (!seen_current[FineBit]) amps = amps * 10;
      if (amps > 32767) amps = 32767;
      res.frame_ok = 1'b1;
      res.status_flags = seen_flags;
      if (seen_flags[1])      res.fault_code = FaultBit1;
      else if (seen_flags[3]) res.fault_code = FaultBit3;
      else if (seen_flags[0]) res.fault_code = FaultBit0;
      else if (seen_flags[5]) res.fault_code = FaultBit5;
      else if (seen_flags[4]) res.fault_code = FaultBit4;
      else if (seen_flags[6]) res.fault_code = FaultBit6;
      else                    res.fault_code = FaultNone;
      res.flag_two = seen_flags[2];
      res.flag_seven = seen_flags[7];
      res.current_deciamps = 15'(amps);
      res.period_millis = seen_period;
      res.charge_percent = seen_charge;
      res.charge_valid = (seen_charge <= ChargeMax);
    end

    // next byte opens a new frame
    seen_count = '0;
    seen_start_ok = 1'b0;
    seen_length = '0;
    seen_command = '0;
    seen_flags = '0;
    seen_current = '0;
    seen_period = '0;
    seen_charge = '0;
    return 1'b1;
  endfunction

  task automatic flag_error(input string msg);
    mismatch_count++;
    $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      flag_error($sformatf("frame %0d %s: got 0x%0h, want 0x%0h",
                           frames_checked, name, got, want));
  endtask

  // offer one byte item, wait for it to be taken, then log what it decodes to
  task automatic put_byte(input logic [7:0] b, input logic last, input logic typed,
                          input msfd_out_t want);
    msfd_out_t res;
    @(negedge clk);
    while (!steady_tx && $urandom_range(0, 99) < 30) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{rx_byte: b, frame_end: last};
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    if (decode_byte(b, last, res)) decoded_q.push_back(typed ? want : res);
  endtask

  // stimulus
  initial begin
    int unsigned frame_no;
    int unsigned flen;
    int unsigned kind;
    logic [7:0]  frame [$];
    logic [15:0] cur;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (ByteRows[i])
      put_byte(ByteRows[i].rx_byte, ByteRows[i].frame_end, ByteRows[i].typed,
               ByteRows[i].want);

    // random frames: mostly well formed with random content, some noise
    frame_no = 0;
    while (bytes_sent < ItemsTarget) begin
      if (frame_no == LongFrameNo) begin
        flen = $urandom_range(256, 260);
      end else begin
        kind = $urandom_range(0, 99);
        if (kind < 15)      flen = $urandom_range(1, 13);
        else if (kind < 90) flen = $urandom_range(14, 20);
        else                flen = $urandom_range(21, 40);
      end
      frame = {};
      repeat (flen) frame.push_back(8'($urandom_range(0, 255)));

      if ($urandom_range(0, 19) != 0) frame[0] = StartCode;
      if (flen > 1 && $urandom_range(0, 9) != 0)
        frame[1] = 8'($urandom_range(MinFrameLen, (flen > 255) ? 255 : flen));
      if (flen > 2 && $urandom_range(0, 9) != 0) frame[2] = StatusCmd;
      if (flen > 3) begin
        // single flag bits walk every fault code
        case ($urandom_range(0, 3))
          0: frame[3] = 8'h01 << $urandom_range(0, 7);
          1: frame[3] = 8'h00;
          default: ;
        endcase
      end
      if (flen > 6) begin
        cur = 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 3))
          0: cur[FineBit] = 1'b1;
          1: begin
            // coarse scale around the saturation point
            cur[FineBit] = 1'b0;
            cur[13:0] = 14'($urandom_range(3270, 3290));
          end
          default: ;
        endcase
        frame[5] = cur[15:8];
        frame[6] = cur[7:0];
      end
      if (flen > 10 && $urandom_range(0, 2) == 0)
        frame[10] = 8'($urandom_range(98, 102));

      steady_tx = (frame_no >= 15 && frame_no < 22);
      foreach (frame[i]) put_byte(frame[i], i == frame.size() - 1, 1'b0, NoFrame);

      if (frame_no == PauseFrameNo) begin
        // hold back until every decoded frame has come out
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge clk);
      end
      frame_no++;
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("motor_status_frame_decoder regression: pass");
    end else begin
      $display("motor_status_frame_decoder regression: fail");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off that backs the decoder up,
  // and a stretch of steady acceptance
  initial begin
    int unsigned rx_cycle;
    rx_cycle = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle >= 400 && rx_cycle < 480)
        out_ch.ready <= 1'b0;
      else if (rx_cycle >= 700 && rx_cycle < 1000)
        out_ch.ready <= 1'b1;
      else
        out_ch.ready <= ($urandom_range(0, 99) >= 30);
    end
  end

  // compare each delivered frame item with the oldest decoded one
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_frame = out_ch.data;
      if (decoded_q.size() == 0) begin
        flag_error($sformatf("frame item 0x%0h with no frame pending", got_frame));
      end else begin
        want_frame = decoded_q.pop_front();
        check_field("frame_ok", 32'(got_frame.frame_ok), 32'(want_frame.frame_ok));
        check_field("status_flags", 32'(got_frame.status_flags),
                    32'(want_frame.status_flags));
        check_field("fault_code", 32'(got_frame.fault_code), 32'(want_frame.fault_code));
        check_field("flag_two", 32'(got_frame.flag_two), 32'(want_frame.flag_two));
        check_field("flag_seven", 32'(got_frame.flag_seven), 32'(want_frame.flag_seven));
        check_field("current_deciamps", 32'(got_frame.current_deciamps),
                    32'(want_frame.current_deciamps));
        check_field("period_millis", 32'(got_frame.period_millis),
                    32'(want_frame.period_millis));
        check_field("charge_percent", 32'(got_frame.charge_percent),
                    32'(want_frame.charge_percent));
        check_field("charge_valid", 32'(got_frame.charge_valid),
                    32'(want_frame.charge_valid));
      end
      frames_checked++;
    end
  end

  // hang detection: no item moving on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("%0t ns: no item moved for %0d cycles", $time, QuietLimit);
      $display("motor_status_frame_decoder regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
